[rtl/ptt_pkg.sv]
`default_nettype none
package ptt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  localparam int IN_DATA_W  = 232;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIRE   = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DUP_ID      = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_ZERO_PERIOD = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_QUERY,
    RES_PEND
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DIV,
    S_FUPD,
    S_RESP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     idx_clr;
    logic     idx_inc;
    logic     append;
    logic     shift_step;
    logic     dec_count;
    logic     div_start;
    logic     div_step;
    logic     fire_upd;
    logic     min_upd;
    logic     set_status;
    status_t  status_code;
    logic     push;
    res_sel_t sel;
    logic     push_last;
  } ptt_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  at_end;
    logic  id_match;
    logic  is_due;
    logic  div_last;
    logic  out_free;
    logic  count_full;
    logic  period_zero;
    logic  pend_valid;
  } ptt_sts_t;

endpackage
`default_nettype wire

[rtl/ptt_ctrl.sv]
`default_nettype none
module ptt_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  ptt_pkg::ptt_sts_t    sts,
  output ptt_pkg::ptt_cmd_t    cmd
);
  import ptt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status_code = ST_OK;
    cmd.sel = RES_PLAIN;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.mode)
          MODE_ADD: begin
            if (sts.at_end) begin
              if (sts.count_full) begin
                cmd.set_status = 1'b1;
                cmd.status_code = ST_FULL;
              end else if (sts.period_zero) begin
                cmd.set_status = 1'b1;
                cmd.status_code = ST_ZERO_PERIOD;
              end else begin
                cmd.append = 1'b1;
              end
              state_nxt = S_RESP;
            end else if (sts.id_match) begin
              cmd.set_status = 1'b1;
              cmd.status_code = ST_DUP_ID;
              state_nxt = S_RESP;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (sts.at_end) begin
              cmd.set_status = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end else if (sts.id_match) begin
              // The pointer moves to the source of the first move-down step.
              cmd.idx_inc = 1'b1;
              state_nxt = S_SHIFT;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          MODE_FIRE: begin
            if (sts.at_end) begin
              state_nxt = S_FIN;
            end else if (sts.is_due) begin
              // A held fire result goes out first, since another one follows it.
              if (!sts.pend_valid || sts.out_free) begin
                if (sts.pend_valid) begin
                  cmd.push = 1'b1;
                  cmd.sel = RES_PEND;
                end
                cmd.div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          default: begin
            if (sts.at_end) begin
              state_nxt = S_RESP;
            end else begin
              cmd.min_upd = 1'b1;
              cmd.idx_inc = 1'b1;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (sts.at_end) begin
          cmd.dec_count = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FUPD;
        end
      end
      S_FUPD: begin
        cmd.fire_upd = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = S_SCAN;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          cmd.sel = (sts.mode == MODE_QUERY) ? RES_QUERY : RES_PLAIN;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          cmd.sel = sts.pend_valid ? RES_PEND : RES_PLAIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/ptt_dp.sv]
`default_nettype none
module ptt_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  ptt_pkg::ptt_cmd_t                 cmd,
  output ptt_pkg::ptt_sts_t                 sts,
  input  wire [ptt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire [ptt_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [ptt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [ptt_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import ptt_pkg::*;

  // Timer table, read at the scan pointer only.
  logic [7:0]  id_q     [TIMER_SLOTS];
  logic [63:0] start_q  [TIMER_SLOTS];
  logic [31:0] period_q [TIMER_SLOTS];
  logic [63:0] due_q    [TIMER_SLOTS];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;

  mode_t       mode_r;
  logic [7:0]  id_r;
  logic [63:0] start_r;
  logic [31:0] period_r;
  logic [63:0] first_r;
  logic [63:0] now_r;
  status_t     status_r;
  logic [63:0] min_r;

  logic [63:0] dvd_r;
  logic [31:0] rem_r;
  logic [5:0]  dcnt_r;

  logic        pend_v_r;
  logic [7:0]  pend_id_r;
  logic [63:0] pend_el_r;
  logic [63:0] pend_due_r;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic        out_fired_r;
  logic        out_last_r;

  logic [IDX_W-1:0] ridx;
  logic [IDX_W-1:0] widx_shift;
  logic [7:0]  rd_id;
  logic [63:0] rd_start;
  logic [31:0] rd_period;
  logic [63:0] rd_due;
  logic [32:0] trial;
  logic [63:0] new_due;
  logic        out_free;

  assign ridx       = idx_r[IDX_W-1:0];
  assign widx_shift = ridx - IDX_W'(1);
  assign rd_id      = id_q[ridx];
  assign rd_start   = start_q[ridx];
  assign rd_period  = period_q[ridx];
  assign rd_due     = due_q[ridx];

  assign trial   = {rem_r, dvd_r[63]};
  // start + ((due - start) / p + 1) * p equals due - ((due - start) mod p) + p.
  assign new_due = rd_due - {32'd0, rem_r} + {32'd0, rd_period};
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts.mode        = mode_r;
    sts.at_end      = idx_r >= count_r;
    sts.id_match    = (rd_id == id_r) && (idx_r < count_r);
    sts.is_due      = now_r > rd_due;
    sts.div_last    = dcnt_r == 6'd63;
    sts.out_free    = out_free;
    sts.count_full  = count_r >= CNT_W'(TIMER_SLOTS);
    sts.period_zero = period_r == 32'd0;
    sts.pend_valid  = pend_v_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      id_q[count_r[IDX_W-1:0]]     <= id_r;
      start_q[count_r[IDX_W-1:0]]  <= start_r;
      period_q[count_r[IDX_W-1:0]] <= period_r;
      due_q[count_r[IDX_W-1:0]]    <= first_r;
    end
    if (cmd.shift_step) begin
      id_q[widx_shift]     <= rd_id;
      start_q[widx_shift]  <= rd_start;
      period_q[widx_shift] <= rd_period;
      due_q[widx_shift]    <= rd_due;
    end
    if (cmd.fire_upd) begin
      due_q[ridx] <= new_due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_ADD;
      status_r    <= ST_OK;
      dcnt_r      <= '0;
    end else begin
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc || cmd.shift_step) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.load) begin
        mode_r   <= mode_t'(in_tuser[1:0]);
        status_r <= ST_OK;
      end else if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.div_start) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 6'd1;
      end
      if (cmd.load || (cmd.push && cmd.sel == RES_PEND)) begin
        pend_v_r <= 1'b0;
      end else if (cmd.fire_upd) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r     <= in_tdata[7:0];
      start_r  <= in_tdata[71:8];
      period_r <= in_tdata[103:72];
      first_r  <= in_tdata[167:104];
      now_r    <= in_tdata[231:168];
      min_r    <= '1;
    end else if (cmd.min_upd && rd_due < min_r) begin
      min_r <= rd_due;
    end
    if (cmd.div_start) begin
      dvd_r <= rd_due - rd_start;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      if (trial >= {1'b0, rd_period}) begin
        rem_r <= 32'(trial - {1'b0, rd_period});
      end else begin
        rem_r <= trial[31:0];
      end
    end
    if (cmd.fire_upd) begin
      pend_id_r  <= rd_id;
      pend_el_r  <= now_r - rd_start;
      pend_due_r <= new_due;
    end
    if (cmd.push) begin
      out_last_r <= cmd.push_last;
      case (cmd.sel)
        RES_PEND: begin
          out_fired_r <= 1'b1;
          out_data_r  <= {5'(count_r), pend_due_r, pend_el_r, pend_id_r, ST_OK};
        end
        RES_QUERY: begin
          out_fired_r <= 1'b0;
          out_data_r  <= {5'(count_r), min_r, 64'd0, 8'd0, ST_OK};
        end
        default: begin
          out_fired_r <= 1'b0;
          out_data_r  <= {5'(count_r), 64'd0, 64'd0, 8'd0, status_r};
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TIMER_SLOTS))
    else $error("timer count above table size");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> out_free)
    else $error("result pushed over an untaken result");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not grow the table");

  a_div_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> idx_r < count_r)
    else $error("division started outside the table");

endmodule
`default_nettype wire

[rtl/periodic_timer_table_unit.sv]
`default_nettype none
// Channel   Direction  Transaction
// in_*      input      one command: add, remove, advance time and fire, or query
// out_*     output     one result; out_tlast marks the final result of a command
//
// Add, remove and query walk the table one slot per cycle. A fire walks the table
// and works out each due timer's next due time in the bit-serial 64-by-32
// remainder unit, waiting while a held result cannot go out.
// One command is worked at a time; in_tready is high only while the block is idle.
// A stalled out_tready holds the result register and pauses the walk before the
// next push. Reset empties the table at once; no clearing pass is needed.
module periodic_timer_table_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // timer_id[7:0], start_time[71:8], period[103:72], first_due[167:104], now[231:168]
  input  wire [ptt_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[1:0]
  input  wire [ptt_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // status[2:0], fired_id[10:3], elapsed[74:11], due_time[138:75], timer_count[143:139]
  output logic [ptt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // fired[0]
  output logic [ptt_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import ptt_pkg::*;

  ptt_cmd_t cmd;
  ptt_sts_t sts;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[test/periodic_timer_table_unit_test.sv]
`default_nettype none

class timer_scoreboard;
  typedef struct {
    ptt_pkg::status_t status;
    bit        fired;
    bit [7:0]  fired_id;
    bit [63:0] elapsed;
    bit [63:0] due_time;
    bit [4:0]  timer_count;
    bit        last;
  } timer_result_t;

  bit [7:0]  ids [16];
  bit [63:0] starts [16];
  bit [31:0] periods [16];
  bit [63:0] dues [16];
  int        count;
  timer_result_t awaited [$];
  int        errors;

  function int find_timer(bit [7:0] id);
    for (int i = 0; i < count; i++) begin
      if (ids[i] == id) return i;
    end
    return -1;
  endfunction

  function void push_result(ptt_pkg::status_t st, bit f, bit [7:0] id,
                            bit [63:0] el, bit [63:0] due, bit lst);
    timer_result_t r;
    r.status = st;
    r.fired = f;
    r.fired_id = id;
    r.elapsed = el;
    r.due_time = due;
    r.timer_count = count[4:0];
    r.last = lst;
    awaited = {awaited, r};
  endfunction

  // Works out the results of one accepted command and updates the table copy.
  function void note_command(ptt_pkg::mode_t mode, bit [7:0] id, bit [63:0] start,
                             bit [31:0] period, bit [63:0] first, bit [63:0] now);
    int pos;
    int n;
    bit [63:0] least;
    bit [63:0] calls;
    case (mode)
      ptt_pkg::MODE_ADD: begin
        if (find_timer(id) >= 0) push_result(ptt_pkg::ST_DUP_ID, 0, 0, 0, 0, 1);
        else if (count >= 16) push_result(ptt_pkg::ST_FULL, 0, 0, 0, 0, 1);
        else if (period == 0) push_result(ptt_pkg::ST_ZERO_PERIOD, 0, 0, 0, 0, 1);
        else begin
          ids[count] = id;
          starts[count] = start;
          periods[count] = period;
          dues[count] = first;
          count++;
          push_result(ptt_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
      end
      ptt_pkg::MODE_REMOVE: begin
        pos = find_timer(id);
        if (pos < 0) push_result(ptt_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1);
        else begin
          for (int i = pos; i + 1 < count; i++) begin
            ids[i] = ids[i+1];
            starts[i] = starts[i+1];
            periods[i] = periods[i+1];
            dues[i] = dues[i+1];
          end
          count--;
          push_result(ptt_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
      end
      ptt_pkg::MODE_FIRE: begin
        n = 0;
        for (int i = 0; i < count; i++) begin
          if (now > dues[i]) begin
            calls = (dues[i] - starts[i]) / {32'd0, periods[i]} + 64'd1;
            dues[i] = starts[i] + calls * {32'd0, periods[i]};
            push_result(ptt_pkg::ST_OK, 1, ids[i], now - starts[i], dues[i], 0);
            n++;
          end
        end
        if (n == 0) push_result(ptt_pkg::ST_OK, 0, 0, 0, 0, 1);
        else awaited[$].last = 1;
      end
      default: begin
        least = '1;
        for (int i = 0; i < count; i++) begin
          if (dues[i] < least) least = dues[i];
        end
        push_result(ptt_pkg::ST_OK, 0, 0, 0, least, 1);
      end
    endcase
  endfunction

  function void check_result(bit [ptt_pkg::OUT_DATA_W-1:0] data, bit fired, bit lst);
    timer_result_t e;
    if (awaited.size() == 0) begin
      $error("result transaction with nothing awaited");
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (data[2:0] != e.status) begin
      $error("status: expected %0d, got %0d", e.status, data[2:0]);
      errors++;
    end
    if (fired != e.fired) begin
      $error("fired: expected %0d, got %0d", e.fired, fired);
      errors++;
    end
    if (data[10:3] != e.fired_id) begin
      $error("fired_id: expected %0d, got %0d", e.fired_id, data[10:3]);
      errors++;
    end
    if (data[74:11] != e.elapsed) begin
      $error("elapsed: expected %h, got %h", e.elapsed, data[74:11]);
      errors++;
    end
    if (data[138:75] != e.due_time) begin
      $error("due_time: expected %h, got %h", e.due_time, data[138:75]);
      errors++;
    end
    if (data[143:139] != e.timer_count) begin
      $error("timer_count: expected %0d, got %0d", e.timer_count, data[143:139]);
      errors++;
    end
    if (lst != e.last) begin
      $error("last: expected %0d, got %0d", e.last, lst);
      errors++;
    end
  endfunction
endclass

module periodic_timer_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast;

  timer_scoreboard board = new();
  int send_idle_pct = 18;
  int recv_idle_pct = 52;
  int hold_cycles = 0;
  int cycles = 0;
  bit [63:0] clock_now = 64'd5000;

  periodic_timer_table_unit uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("periodic_timer_table_unit regression: fail");
      $finish;
    end
  end

  // Result side: checks each transaction and draws the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tuser[0], out_tlast);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_command(mode_t mode, bit [7:0] id, bit [63:0] start,
                              bit [31:0] period, bit [63:0] first, bit [63:0] now);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {now, first, period, start, id};
    do @(posedge clk); while (!in_tready);
    board.note_command(mode, id, start, period, first, now);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic bit [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  task automatic random_command();
    int pick;
    bit [7:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(23));
    if (pick < 38) begin
      if ($urandom_range(9) == 0)
        send_command(MODE_ADD, id, wide_random(), $urandom, wide_random(), 0);
      else
        send_command(MODE_ADD, id, clock_now - $urandom_range(2000),
                     ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(1, 700)),
                     clock_now + $urandom_range(1500), 0);
    end else if (pick < 58) begin
      send_command(MODE_REMOVE, id, 0, 0, 0, 0);
    end else if (pick < 88) begin
      clock_now += $urandom_range(1200);
      send_command(MODE_FIRE, 0, 0, 0, 0,
                   ($urandom_range(14) == 0) ? wide_random() : clock_now);
    end else begin
      send_command(MODE_QUERY, 0, 0, 0, 0, 0);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table cases, refusals and a full table that fires at once.
    send_command(MODE_QUERY, 0, 0, 0, 0, 0);
    send_command(MODE_FIRE, 0, 0, 0, 0, '1);
    send_command(MODE_REMOVE, 8'd255, 0, 0, 0, 0);
    send_command(MODE_ADD, 8'd0, '1, 32'd0, '1, 0);
    send_command(MODE_ADD, 8'd255, '1, '1, 64'd0, '1);
    send_command(MODE_ADD, 8'd255, 0, 32'd5, 0, 0);
    for (int i = 1; i < 16; i++)
      send_command(MODE_ADD, 8'(i), 64'd100 * i, 32'(i), 64'd1000 + i, 0);
    send_command(MODE_ADD, 8'd200, 0, 32'd3, 0, 0);
    send_command(MODE_QUERY, 0, 0, 0, 0, 0);
    send_command(MODE_FIRE, 0, 0, 0, 0, '1);
    send_command(MODE_FIRE, 0, 0, 0, 0, 64'd1005);
    send_command(MODE_REMOVE, 8'd7, 0, 0, 0, 0);
    send_command(MODE_REMOVE, 8'd255, 0, 0, 0, 0);
    wait_drained();
    for (int i = 1; i < 16; i++)
      if (i != 7) send_command(MODE_REMOVE, 8'(i), 0, 0, 0, 0);

    // Long receiver hold-off while commands keep coming.
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) random_command();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < 55; i++) random_command();
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("periodic_timer_table_unit regression: pass");
    else
      $display("periodic_timer_table_unit regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
rtl/ptt_pkg.sv
rtl/ptt_ctrl.sv
rtl/ptt_dp.sv
rtl/periodic_timer_table_unit.sv
test/periodic_timer_table_unit_test.sv
